FILE: rtl/core/natg_pkg.sv
// ----------------------------------------------------------------------------
// natg_pkg
// Shared constants, types and controller codes for the axis tick generator.
// ----------------------------------------------------------------------------
package natg_pkg;

  localparam int DECIMAL_DIGITS = 3;
  localparam int MAX_TICKS      = 32;
  localparam int CNT_W          = $clog2(MAX_TICKS);

  localparam logic [33:0] UNIT = 34'(10 ** DECIMAL_DIGITS);
  localparam logic [32:0] HALF = 33'(10 ** DECIMAL_DIGITS / 2);

  localparam logic [CNT_W-1:0] LAST_COUNT = CNT_W'(MAX_TICKS - 1);

  localparam logic [2:0] REG_TARGET_TICKS = 3'd0;
  localparam logic [4:0] TARGET_RESET     = 5'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NICE,
    ST_ROUND,
    ST_DIV_LO,
    ST_FIX_LO,
    ST_DIV_HI,
    ST_FIX_HI,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic nice_init;
    logic nice_step;
    logic round_init;
    logic round_step;
    logic div_init;
    logic div_sel_hi;
    logic div_step;
    logic fix_lo;
    logic fix_hi;
    logic emit_init;
    logic emit_step;
  } natg_cmd_t;

  typedef struct packed {
    logic nice_hit;
    logic round_hit;
    logic div_last;
    logic emit_last;
  } natg_status_t;

endpackage

FILE: rtl/core/natg_datapath.sv
// ----------------------------------------------------------------------------
// natg_datapath
// Range ordering, 1-2-5 rounding, remainder unit and tick counter.
// ----------------------------------------------------------------------------
module natg_datapath import natg_pkg::*; (
  input  logic               clk,
  input  natg_cmd_t          cmd,
  output natg_status_t       status,
  input  logic        [4:0]  target_ticks,
  input  logic signed [30:0] range_low,
  input  logic signed [30:0] range_high,
  output logic signed [35:0] tick_value,
  output logic        [33:0] tick_step,
  output logic               last_tick
);

  logic signed [32:0] lo, hi;
  logic        [34:0] p;
  logic        [33:0] nice;
  logic        [37:0] prod;
  logic        [33:0] step;
  logic        [31:0] m;
  logic        [33:0] rem;
  logic        [4:0]  cnt;
  logic signed [35:0] first, last, t;
  logic [CNT_W-1:0]   count;

  logic signed [32:0] a_ext, b_ext;
  logic        [31:0] span;
  logic        [36:0] p1, p2, p5;
  logic        [4:0]  den;
  logic        [37:0] prod10, num2, prod3, prod7;
  logic        [34:0] rem_sh;
  logic signed [32:0] x;
  logic signed [35:0] x36, rem36, step36, t_next;

  assign a_ext  = 33'(range_low);
  assign b_ext  = 33'(range_high);
  assign span   = 32'(hi - lo);
  assign p1     = 37'(p);
  assign p2     = 37'(p) << 1;
  assign p5     = (37'(p) << 2) + 37'(p);
  assign den    = (target_ticks >= 5'd2) ? target_ticks - 5'd1 : 5'd1;
  assign prod10 = (prod << 3) + (prod << 1);
  assign num2   = 38'(nice) << 1;
  assign prod3  = (prod << 1) + prod;
  assign prod7  = (prod << 3) - prod;
  assign rem_sh = {rem, m[31]};
  assign x      = cmd.div_sel_hi ? hi : lo;
  assign x36    = cmd.fix_hi ? 36'(hi) : 36'(lo);
  assign rem36  = 36'(rem);
  assign step36 = 36'(step);
  assign t_next = t + step36;

  assign status.nice_hit  = (span == 32'd0) || (37'(span) <= p5);
  assign status.round_hit = (nice < 34'(den)) || (prod10 > 38'(nice));
  assign status.div_last  = (cnt == 5'd31);
  assign status.emit_last = (t_next > last) || (count == LAST_COUNT);

  assign tick_value = t;
  assign tick_step  = step;
  assign last_tick  = status.emit_last;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      if (a_ext == b_ext) begin
        lo <= a_ext - HALF;
        hi <= a_ext + HALF;
      end else if (a_ext > b_ext) begin
        lo <= b_ext;
        hi <= a_ext;
      end else begin
        lo <= a_ext;
        hi <= b_ext;
      end
    end
    if (cmd.nice_init || cmd.round_init) begin
      p <= 35'd1;
    end
    if (cmd.nice_step) begin
      if (span == 32'd0) begin
        nice <= UNIT;
      end else if (37'(span) <= p1) begin
        nice <= 34'(p1);
      end else if (37'(span) <= p2) begin
        nice <= 34'(p2);
      end else if (37'(span) <= p5) begin
        nice <= 34'(p5);
      end else begin
        p <= 35'((p1 << 3) + (p1 << 1));
      end
    end
    if (cmd.round_init) begin
      prod <= 38'(den);
    end
    if (cmd.round_step) begin
      if (nice < 34'(den)) begin
        step <= 34'd1;
      end else if (prod10 <= 38'(nice)) begin
        prod <= prod10;
        p    <= 35'((p1 << 3) + (p1 << 1));
      end else if (num2 < prod3) begin
        step <= 34'(p1);
      end else if (38'(nice) < prod3) begin
        step <= 34'(p2);
      end else if (38'(nice) < prod7) begin
        step <= 34'(p5);
      end else begin
        step <= 34'((p1 << 3) + (p1 << 1));
      end
    end
    if (cmd.div_init) begin
      m   <= 32'(x[32] ? -x : x);
      rem <= 34'd0;
      cnt <= 5'd0;
    end
    if (cmd.div_step) begin
      rem <= (rem_sh >= 35'(step)) ? 34'(rem_sh - 35'(step)) : rem_sh[33:0];
      m   <= m << 1;
      cnt <= cnt + 5'd1;
    end
    if (cmd.fix_lo) begin
      if (!x36[35]) begin
        first <= x36 - rem36;
      end else begin
        first <= x36 + rem36 - ((rem != 34'd0) ? step36 : 36'sd0);
      end
    end
    if (cmd.fix_hi) begin
      if (!x36[35]) begin
        last <= x36 - rem36 + ((rem != 34'd0) ? step36 : 36'sd0);
      end else begin
        last <= x36 + rem36;
      end
    end
    if (cmd.emit_init) begin
      t     <= first;
      count <= '0;
    end
    if (cmd.emit_step) begin
      t     <= t_next;
      count <= count + CNT_W'(1);
    end
  end

endmodule

FILE: rtl/core/natg_controller.sv
// ----------------------------------------------------------------------------
// natg_controller
// Sequencer for one request: round span, pick step, align ends, emit ticks.
// ----------------------------------------------------------------------------
module natg_controller import natg_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  output logic         busy,
  output logic         result_valid,
  input  natg_status_t status,
  output natg_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    busy         = 1'b1;
    result_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load      = 1'b1;
          cmd.nice_init = 1'b1;
          state_next    = ST_NICE;
        end
      end
      ST_NICE: begin
        cmd.nice_step = 1'b1;
        if (status.nice_hit) begin
          cmd.round_init = 1'b1;
          state_next     = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round_step = 1'b1;
        if (status.round_hit) begin
          state_next = ST_DIV_LO;
        end
      end
      ST_DIV_LO: begin
        if (status.div_last) begin
          cmd.div_step = 1'b1;
          state_next   = ST_FIX_LO;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_FIX_LO: begin
        cmd.fix_lo     = 1'b1;
        cmd.div_init   = 1'b1;
        cmd.div_sel_hi = 1'b1;
        state_next     = ST_DIV_HI;
      end
      ST_DIV_HI: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_FIX_HI;
        end
      end
      ST_FIX_HI: begin
        cmd.fix_hi    = 1'b1;
        cmd.emit_init = 1'b1;
        state_next    = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit_step = 1'b1;
        result_valid  = 1'b1;
        if (status.emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    if (state == ST_ROUND && status.round_hit) begin
      cmd.div_init = 1'b1;
    end
  end

endmodule

FILE: rtl/core/nice_axis_tick_generator_unit.sv
// ----------------------------------------------------------------------------
// nice_axis_tick_generator_unit
// Ticks: one tick per cycle once the tick run starts.
// Requests: one at a time; busy stays high through the decade search,
// the two remainder passes and the tick run (up to MAX_TICKS).
// Reset: synchronous; sequencer idles and target_ticks returns to 5.
// Results carry a one-cycle strobe and cannot be stalled.
// ----------------------------------------------------------------------------
module nice_axis_tick_generator_unit import natg_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [30:0] range_low,
  input  logic signed [30:0] range_high,
  output logic               result_valid,
  output logic signed [35:0] tick_value,
  output logic        [33:0] tick_step,
  output logic               last_tick,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [2:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);

  logic [4:0]   target_ticks;
  natg_cmd_t    cmd;
  natg_status_t status;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_TARGET_TICKS) ? {27'd0, target_ticks} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_ticks <= TARGET_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_TARGET_TICKS) begin
      target_ticks <= pwdata[4:0];
    end
  end

  natg_controller u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .result_valid (result_valid),
    .status       (status),
    .cmd          (cmd)
  );

  natg_datapath u_dp (
    .clk          (clk),
    .cmd          (cmd),
    .status       (status),
    .target_ticks (target_ticks),
    .range_low    (range_low),
    .range_high   (range_high),
    .tick_value   (tick_value),
    .tick_step    (tick_step),
    .last_tick    (last_tick)
  );

endmodule

FILE: test/nice_axis_tick_generator_unit_test.sv
// ----------------------------------------------------------------------------
// nice_axis_tick_generator_unit_test
// Drives data ranges through the tick generator under several target_ticks
// settings and sender idle patterns, predicts every 1-2-5 tick run and
// checks each tick strobe, in order, against the prediction.
// ----------------------------------------------------------------------------
module nice_axis_tick_generator_unit_test;
  import natg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic [35:0] value;
    logic [33:0] step;
    logic        fin;
  } tick_t;

  class tick_scoreboard;
    tick_t      pending[$];
    int         errors = 0;
    logic [4:0] target = TARGET_RESET;

    function longint nice_up(longint span);
      longint p;
      p = 1;
      for (int i = 0; i < 19; i++) begin
        if (span <= p) return p;
        if (span <= 2 * p) return 2 * p;
        if (span <= 5 * p) return 5 * p;
        p = p * 10;
      end
      return p;
    endfunction

    function longint nice_round(longint num, longint den);
      longint p;
      p = 1;
      if (num < den) return 1;
      while (p * 10 * den <= num) p = p * 10;
      if (2 * num < 3 * p * den) return p;
      if (num < 3 * p * den) return 2 * p;
      if (num < 7 * p * den) return 5 * p;
      return 10 * p;
    endfunction

    function longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q--;
      return q;
    endfunction

    function void note_request(logic signed [30:0] lo_in, logic signed [30:0] hi_in);
      longint lo, hi, tmp, unit, span, span_nice, divs, s, t_first, t_last, t;
      int     count;
      tick_t  tk;
      lo = lo_in;
      hi = hi_in;
      unit = 10 ** DECIMAL_DIGITS;
      if (lo > hi) begin
        tmp = lo; lo = hi; hi = tmp;
      end
      if (lo == hi) begin
        lo -= unit / 2;
        hi += unit / 2;
      end
      span = hi - lo;
      span_nice = (span == 0) ? unit : nice_up(span);
      divs = (target >= 2) ? longint'(target) - 1 : 1;
      s = nice_round(span_nice, divs);
      t_first = floor_div(lo, s) * s;
      t_last = -floor_div(-hi, s) * s;
      count = 0;
      for (t = t_first; t <= t_last && count < MAX_TICKS; t += s) begin
        tk.value = t[35:0];
        tk.step = s[33:0];
        tk.fin = (t + s > t_last) || (count == MAX_TICKS - 1);
        pending.insert(pending.size(), tk);
        count++;
      end
    endfunction

    function void check_tick(logic [35:0] v, logic [33:0] s, logic fin);
      tick_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected tick value=%0d step=%0d last=%0b",
                 $time, $signed(v), s, fin);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.value !== v) begin
        $display("%0t: tick_value expected %0d actual %0d", $time, $signed(e.value),
                 $signed(v));
        errors++;
      end
      if (e.step !== s) begin
        $display("%0t: tick_step expected %0d actual %0d", $time, e.step, s);
        errors++;
      end
      if (e.fin !== fin) begin
        $display("%0t: last_tick expected %0b actual %0b", $time, e.fin, fin);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [30:0] range_low = '0;
  logic signed [30:0] range_high = '0;
  logic               result_valid;
  logic signed [35:0] tick_value;
  logic        [33:0] tick_step;
  logic               last_tick;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic        [2:0]  paddr = '0;
  logic        [31:0] pwdata = '0;
  logic        [31:0] prdata;
  logic               pready;

  tick_scoreboard sb = new();
  int             idle_cycles = 0;

  nice_axis_tick_generator_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .range_low(range_low), .range_high(range_high),
    .result_valid(result_valid), .tick_value(tick_value),
    .tick_step(tick_step), .last_tick(last_tick),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && result_valid) sb.check_tick(tick_value, tick_step, last_tick);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("nice_axis_tick_generator_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_range(logic signed [30:0] lo, logic signed [30:0] hi);
    @(negedge clk);
    start <= 1'b1;
    range_low <= lo;
    range_high <= hi;
    do @(posedge clk); while (busy);
    sb.note_request(lo, hi);
  endtask

  task automatic hold_start(int cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain();
    hold_start(0);
    while (sb.pending.size() != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_target(logic [4:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= REG_TARGET_TICKS << 2;
    pwdata <= {$urandom} & 32'hFFFF_FFE0 | 32'(val);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.target = val;
  endtask

  function automatic logic signed [30:0] rand_end();
    case ($urandom_range(0, 3))
      0: return 31'($urandom);
      1: return 31'($signed(32'($urandom_range(0, 20000))) - 10000);
      2: return $urandom_range(0, 1) ? 31'h3FFF_FFFF - 31'($urandom_range(0, 50))
                                     : 31'h4000_0000 + 31'($urandom_range(0, 50));
      default: return 31'($signed(32'($urandom_range(0, 2000000))) - 1000000);
    endcase
  endfunction

  task automatic random_phase(int n, int idle_pct);
    logic signed [30:0] lo, hi;
    int                 pause_at;
    pause_at = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      lo = rand_end();
      case ($urandom_range(0, 4))
        0: hi = rand_end();
        1: hi = lo;
        2: hi = lo - 31'($urandom_range(0, 5000));
        default: hi = lo + 31'($urandom_range(0, 10 ** $urandom_range(0, 7)));
      endcase
      if (i == pause_at) drain();
      send_range(lo, hi);
      if ($urandom_range(1, 100) <= idle_pct) hold_start($urandom_range(1, 40));
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_range(31'sh4000_0000, 31'sh3FFF_FFFF);
    send_range(31'sh3FFF_FFFF, 31'sh4000_0000);
    send_range(0, 0);
    send_range(-1, -1);
    send_range(31'sh3FFF_FFFF, 31'sh3FFF_FFFF);
    send_range(31'sh4000_0000, 31'sh4000_0000);
    send_range(1000, 0);
    send_range(0, 1);
    send_range(-7, 3);
    send_range(-1000000000, 1000000000);
    send_range(1234, 98765);
    send_range(-555, -1);
    drain();
    write_target(5'd20);
    send_range(0, 1);
    send_range(0, 31);
    send_range(-3, 3);
    send_range(0, 100000);
    drain();
    write_target(5'd0);
    send_range(0, 1);
    send_range(-999, 12345);
    drain();
    write_target(5'd1);
    send_range(5, 5);
    send_range(-123456, 7);
    drain();
    write_target(5'd31);
    send_range(0, 3);
    send_range(-50000, 50000);
    drain();

    write_target(5'd5);
    random_phase(50, 0);
    write_target(5'd31);
    random_phase(50, 71);
    write_target(5'd0);
    random_phase(50, 0);
    write_target(5'd20);
    random_phase(50, 12);
    write_target(5'd1);
    random_phase(50, 71);
    write_target(5'($urandom_range(2, 19)));
    random_phase(50, 0);
    write_target(5'($urandom_range(0, 31)));
    random_phase(50, 12);

    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("nice_axis_tick_generator_unit verification clean");
    end else begin
      $display("nice_axis_tick_generator_unit verification failed");
    end
    $finish;
  end
endmodule

FILE: nice_axis_tick_generator_unit.f
rtl/core/natg_pkg.sv
rtl/core/natg_datapath.sv
rtl/core/natg_controller.sv
rtl/core/nice_axis_tick_generator_unit.sv
test/nice_axis_tick_generator_unit_test.sv
